// File: hdl/staggered_grid_particle_advection_top_macros.svh
// Assertion macros for the particle advection block.
// Used by staggered_grid_particle_advection_top; needs clk_i and rst_ni in scope.
`ifndef STAGGERED_GRID_PARTICLE_ADVECTION_TOP_MACROS_SVH
`define STAGGERED_GRID_PARTICLE_ADVECTION_TOP_MACROS_SVH

// condition that must hold on every enabled edge
`define SGPA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define SGPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/sgpa_pkg.sv
// Shared types, constants and the fixed-point blend for the particle advection block.
// No dependencies.
`default_nettype none
package sgpa_pkg;

  localparam int unsigned MAX_CELLS_DEF = 16;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned INT_W         = 5;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CFG_W         = 31;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned IN_DATA_W     = 144;
  localparam int unsigned OUT_DATA_W    = 96;

  localparam logic [CFG_W-1:0] CELL_SIZE_RST = 31'd65536;
  localparam logic [CFG_W-1:0] TIME_STEP_RST = 31'd655;
  localparam logic [CNT_W-1:0] CELLS_RST     = 5'd16;

  typedef enum logic [IDX_W-1:0] {
    CFG_CELL_SIZE_X,
    CFG_CELL_SIZE_Y,
    CFG_CELL_SIZE_Z,
    CFG_TIME_STEP,
    CFG_CELLS_X,
    CFG_CELLS_Y,
    CFG_CELLS_Z
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE,
    ACT_ADVANCE
  } action_e;

  typedef enum logic [1:0] {
    COMP_U,
    COMP_V,
    COMP_W
  } comp_e;

  typedef struct packed {
    logic                  action;
    logic [1:0]            comp;
    logic [4:0]            ci;
    logic [4:0]            cj;
    logic [4:0]            ck;
    logic [VAL_W-1:0]      value;
    logic [2:0][VAL_W-1:0] pos;
  } item_t;

  // a*(1-w) + b*w in Q16.16, rounded half up
  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [15:0] w);
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    logic signed [50:0] acc;
    diff = 33'(b) - 33'(a);
    prod = diff * $signed({1'b0, w});
    acc  = 51'(prod) + (51'(a) <<< 16) + 51'sd32768;
    return acc[47:16];
  endfunction

endpackage
`default_nettype wire

// File: hdl/sgpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sgpa_ram #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/sgpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, IW integer and FW fraction bits.
// No dependencies; ovf_o flags a quotient that does not fit IW integer bits.
`default_nettype none
module sgpa_div #(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 32,
  parameter int unsigned IW = 5,
  parameter int unsigned FW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NW-1:0]    n_i,
  input  wire logic [DW-1:0]    d_i,
  output logic      [IW+FW-1:0] q_o,
  output logic                  ovf_o
);

  localparam int unsigned QW = IW + FW;
  localparam int unsigned RW = DW + IW;
  localparam int unsigned XW = ((NW > RW) ? NW : RW) + 1;

  logic [NW-1:0] n0_q;
  logic [DW-1:0] d0_q;
  logic [RW-1:0] r_q  [QW+1];
  logic [DW-1:0] dd_q [QW+1];
  logic [QW-1:0] q_q  [QW+1];
  logic          ov_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q     <= n_i;
      d0_q     <= d_i;
      ov_q[0]  <= XW'(n0_q) >= (XW'(d0_q) << IW);
      r_q[0]   <= RW'(n0_q);
      dd_q[0]  <= d0_q;
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [RW-1:0] cmp;
    logic          bit_d;
    logic [RW-1:0] rem;
    always_comb begin
      cmp   = RW'(dd_q[k-1]) << (IW - 1);
      bit_d = r_q[k-1] >= cmp;
      rem   = bit_d ? (r_q[k-1] - cmp) : r_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= rem << 1;
        dd_q[k] <= dd_q[k-1];
        q_q[k]  <= {q_q[k-1][QW-2:0], bit_d};
        ov_q[k] <= ov_q[k-1];
      end
    end
  end

  assign q_o   = q_q[QW];
  assign ovf_o = ov_q[QW];

endmodule
`default_nettype wire

// File: hdl/staggered_grid_particle_advection_top.sv
// Top level of the staggered-grid particle advection block.
// Depends on sgpa_pkg, sgpa_div, sgpa_ram and the assertion macro header.
//
// Usage: requests enter on the s_axis channel. tuser[0] selects a grid write (0) or a
// particle advance (1); tuser[2:1] names the grid written. A grid write produces no
// result; an advance produces one result on m_axis: the new position in tdata and a
// drop flag in tuser. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write it only while no request is in flight; the block does not enforce it.
// Throughput: one request per cycle while the output does not stall. From acceptance to
// result a request passes the 21-stage quotient pipeline (plus two set-up stages) that
// yields the cell index and weight, then the registered bank read, three blend stages,
// one multiply, one saturating add and the exit check. Each grid is split into eight
// banks by index parity so all eight corners of every grid are read in the same cycle.
// Reset clears all valid bits and restores the default configuration; grid contents
// are undefined until written. When m_axis_tvalid is high and m_axis_tready is low the whole
// pipeline holds and s_axis_tready falls; nothing is lost or repeated.
`default_nettype none
`include "staggered_grid_particle_advection_top_macros.svh"
module staggered_grid_particle_advection_top #(
  parameter int unsigned MAX_CELLS_X = sgpa_pkg::MAX_CELLS_DEF,
  parameter int unsigned MAX_CELLS_Y = sgpa_pkg::MAX_CELLS_DEF,
  parameter int unsigned MAX_CELLS_Z = sgpa_pkg::MAX_CELLS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // cell_i, cell_j, cell_k, cell_value, pos_x, pos_y, pos_z, one pad bit
  input  wire logic [sgpa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action, component
  input  wire logic [2:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // new_x, new_y, new_z
  output logic      [sgpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // dropped
  output logic      [0:0]                       m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [sgpa_pkg::IDX_W-1:0]       cfg_idx_i,
  input  wire logic [sgpa_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned FW      = sgpa_pkg::FRAC_W;
  localparam int unsigned QW      = sgpa_pkg::INT_W + sgpa_pkg::FRAC_W;
  localparam int unsigned DIV_LAT = QW + 2;
  localparam int unsigned GX      = MAX_CELLS_X + 2;
  localparam int unsigned GY      = MAX_CELLS_Y + 2;
  localparam int unsigned GZ      = MAX_CELLS_Z + 2;
  localparam int unsigned ABX     = $clog2((GX + 1) / 2);
  localparam int unsigned ABY     = $clog2((GY + 1) / 2);
  localparam int unsigned ABZ     = $clog2((GZ + 1) / 2);
  localparam int unsigned AW      = ABX + ABY + ABZ;
  localparam int unsigned BANK_D  = 2 ** AW;
  localparam int unsigned MAXC [3] = '{MAX_CELLS_X, MAX_CELLS_Y, MAX_CELLS_Z};

  // ---------------- configuration ----------------
  logic [sgpa_pkg::CFG_W-1:0] cs_q [3];
  logic [sgpa_pkg::CFG_W-1:0] ts_q;
  logic [sgpa_pkg::CNT_W-1:0] cn_q [3];
  logic [sgpa_pkg::CFG_W-1:0] d_eff [3];
  logic [sgpa_pkg::CNT_W-1:0] n_eff [3];
  logic [36:0]                lim [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cs_q[a] <= sgpa_pkg::CELL_SIZE_RST;
        cn_q[a] <= sgpa_pkg::CELLS_RST;
      end
      ts_q <= sgpa_pkg::TIME_STEP_RST;
    end else if (cfg_we_i) begin
      case (sgpa_pkg::cfg_idx_e'(cfg_idx_i))
        sgpa_pkg::CFG_CELL_SIZE_X: cs_q[0] <= cfg_data_i;
        sgpa_pkg::CFG_CELL_SIZE_Y: cs_q[1] <= cfg_data_i;
        sgpa_pkg::CFG_CELL_SIZE_Z: cs_q[2] <= cfg_data_i;
        sgpa_pkg::CFG_TIME_STEP:   ts_q    <= cfg_data_i;
        sgpa_pkg::CFG_CELLS_X:     cn_q[0] <= cfg_data_i[sgpa_pkg::CNT_W-1:0];
        sgpa_pkg::CFG_CELLS_Y:     cn_q[1] <= cfg_data_i[sgpa_pkg::CNT_W-1:0];
        sgpa_pkg::CFG_CELLS_Z:     cn_q[2] <= cfg_data_i[sgpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_eff[a] = (cs_q[a] == '0) ? 31'd1 : cs_q[a];
      n_eff[a] = (32'(cn_q[a]) > MAXC[a]) ? sgpa_pkg::CNT_W'(MAXC[a]) : cn_q[a];
      // first position past the last interior cell
      lim[a]   = {31'b0, 6'({1'b0, n_eff[a]}) + 6'd1} * {6'b0, d_eff[a]};
    end
  end

  // ---------------- input stage ----------------
  logic            pipe_en;
  logic            s0_v_q;
  sgpa_pkg::item_t s0_q;
  sgpa_pkg::item_t in_item;
  logic            out_v_q;

  assign pipe_en       = !out_v_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_comb begin
    in_item.action = s_axis_tuser[0];
    in_item.comp   = s_axis_tuser[2:1];
    in_item.ci     = s_axis_tdata[4:0];
    in_item.cj     = s_axis_tdata[9:5];
    in_item.ck     = s_axis_tdata[14:10];
    in_item.value  = s_axis_tdata[46:15];
    in_item.pos[0] = s_axis_tdata[78:47];
    in_item.pos[1] = s_axis_tdata[110:79];
    in_item.pos[2] = s_axis_tdata[142:111];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (pipe_en) begin
      s0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_q <= in_item;
    end
  end

  // ---------------- cell index and weight dividers ----------------
  logic [QW-1:0] q_lo [3];
  logic [QW-1:0] q_hi [3];
  logic          ov_lo [3];
  logic          ov_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [32:0] n_lo;
    logic [32:0] n_hi;
    // whole cell: p / d; half-shifted cell: (2p + d) / 2d
    assign n_lo = {2'b0, s0_q.pos[a][30:0]};
    assign n_hi = {1'b0, s0_q.pos[a][30:0], 1'b0} + {2'b0, d_eff[a]};

    sgpa_div #(.NW(33), .DW(32), .IW(sgpa_pkg::INT_W), .FW(FW)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .n_i   (n_lo),
      .d_i   ({1'b0, d_eff[a]}),
      .q_o   (q_lo[a]),
      .ovf_o (ov_lo[a])
    );

    sgpa_div #(.NW(33), .DW(32), .IW(sgpa_pkg::INT_W), .FW(FW)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .n_i   (n_hi),
      .d_i   ({d_eff[a], 1'b0}),
      .q_o   (q_hi[a]),
      .ovf_o (ov_hi[a])
    );
  end

  // hold the request alongside the dividers
  logic            dl_v_q [DIV_LAT];
  sgpa_pkg::item_t dl_q   [DIV_LAT];
  sgpa_pkg::item_t dq;
  logic            dq_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) dl_v_q[k] <= 1'b0;
    end else if (pipe_en) begin
      dl_v_q[0] <= s0_v_q;
      for (int k = 1; k < DIV_LAT; k++) dl_v_q[k] <= dl_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dl_q[0] <= s0_q;
      for (int k = 1; k < DIV_LAT; k++) dl_q[k] <= dl_q[k-1];
    end
  end

  assign dq   = dl_q[DIV_LAT-1];
  assign dq_v = dl_v_q[DIV_LAT-1];

  // ---------------- first exit check, bank addressing, grid write ----------------
  logic [4:0]    fl [3];
  logic [4:0]    fh [3];
  logic [15:0]   wf [3];
  logic [15:0]   wh [3];
  logic          drop1;
  logic [4:0]    lsel [3][3];
  logic [15:0]   wsel [3][3];
  logic [5:0]    cx, cy, cz;
  logic [AW-1:0] raddr [3][8];
  logic [AW-1:0] waddr;
  logic          wr_ok;
  logic          we [3][8];
  logic          ram_we_any;
  logic [31:0]   rd [3][8];

  always_comb begin
    drop1 = 1'b0;
    for (int a = 0; a < 3; a++) begin
      fl[a] = q_lo[a][QW-1:FW];
      wf[a] = q_lo[a][FW-1:0];
      fh[a] = q_hi[a][QW-1:FW];
      wh[a] = q_hi[a][FW-1:0];
      if (dq.pos[a][31] || ov_lo[a] || ov_hi[a] || (fh[a] >= n_eff[a])) begin
        drop1 = 1'b1;
      end
    end
    // each grid uses the whole-cell index on its own axis, half-shifted elsewhere
    for (int g = 0; g < 3; g++) begin
      for (int a = 0; a < 3; a++) begin
        lsel[g][a] = (g == a) ? fl[a] : fh[a];
        wsel[g][a] = (g == a) ? wf[a] : wh[a];
      end
    end
    cx = '0;
    cy = '0;
    cz = '0;
    for (int g = 0; g < 3; g++) begin
      for (int b = 0; b < 8; b++) begin
        // pick the low or high corner whose parity matches this bank
        cx = {1'b0, lsel[g][0]} + {5'b0, lsel[g][0][0] ^ b[0]};
        cy = {1'b0, lsel[g][1]} + {5'b0, lsel[g][1][0] ^ b[1]};
        cz = {1'b0, lsel[g][2]} + {5'b0, lsel[g][2][0] ^ b[2]};
        raddr[g][b] = {ABX'(cx >> 1), ABY'(cy >> 1), ABZ'(cz >> 1)};
      end
    end
  end

  assign waddr = {ABX'(dq.ci >> 1), ABY'(dq.cj >> 1), ABZ'(dq.ck >> 1)};
  assign wr_ok = pipe_en && dq_v && (dq.action == sgpa_pkg::ACT_WRITE)
                 && (32'(dq.ci) < GX) && (32'(dq.cj) < GY) && (32'(dq.ck) < GZ);

  always_comb begin
    ram_we_any = 1'b0;
    for (int g = 0; g < 3; g++) begin
      for (int b = 0; b < 8; b++) begin
        // grid number equals its component code; component 3 matches no grid
        we[g][b] = wr_ok && (dq.comp == 2'(g))
                   && ({dq.ck[0], dq.cj[0], dq.ci[0]} == 3'(b));
        ram_we_any = ram_we_any | we[g][b];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_grid
    for (genvar b = 0; b < 8; b++) begin : g_bank
      sgpa_ram #(.W(32), .DEPTH(BANK_D)) u_ram (
        .clk_i   (clk_i),
        .we_i    (we[g][b]),
        .waddr_i (waddr),
        .wdata_i (dq.value),
        .re_i    (pipe_en),
        .raddr_i (raddr[g][b]),
        .rdata_o (rd[g][b])
      );
    end
  end

  // ---------------- blend stages ----------------
  logic               se_v_q, sf_v_q, sg_v_q, sh_v_q, si_v_q, sj_v_q;
  logic               se_drop_q, sf_drop_q, sg_drop_q, sh_drop_q, si_drop_q, sj_drop_q;
  logic [2:0][31:0]   se_pos_q, sf_pos_q, sg_pos_q, sh_pos_q, si_pos_q;
  logic [15:0]        se_w_q [3][3];
  logic [15:0]        sf_w_q [3][3];
  logic [15:0]        sg_w_q [3][3];
  logic               se_lp_q [3][3];
  logic signed [31:0] rx [3][4];
  logic signed [31:0] sf_rx_q [3][4];
  logic signed [31:0] ry [3][2];
  logic signed [31:0] sg_ry_q [3][2];
  logic signed [31:0] sh_vel_q [3];
  logic signed [63:0] si_prod_q [3];
  logic signed [63:0] stp [3];
  logic signed [63:0] sum [3];
  logic signed [31:0] np [3];
  logic [31:0]        sj_np_q [3];
  logic               drop2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_v_q <= 1'b0;
      sf_v_q <= 1'b0;
      sg_v_q <= 1'b0;
      sh_v_q <= 1'b0;
      si_v_q <= 1'b0;
      sj_v_q <= 1'b0;
    end else if (pipe_en) begin
      // grid writes end here
      se_v_q <= dq_v && (dq.action == sgpa_pkg::ACT_ADVANCE);
      sf_v_q <= se_v_q;
      sg_v_q <= sf_v_q;
      sh_v_q <= sg_v_q;
      si_v_q <= sh_v_q;
      sj_v_q <= si_v_q;
    end
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int yz = 0; yz < 4; yz++) begin
        rx[g][yz] = sgpa_pkg::blend(
          rd[g][{yz[1] ^ se_lp_q[g][2], yz[0] ^ se_lp_q[g][1], se_lp_q[g][0]}],
          rd[g][{yz[1] ^ se_lp_q[g][2], yz[0] ^ se_lp_q[g][1], !se_lp_q[g][0]}],
          se_w_q[g][0]);
      end
      for (int z = 0; z < 2; z++) begin
        ry[g][z] = sgpa_pkg::blend(sf_rx_q[g][2*z], sf_rx_q[g][2*z+1], sf_w_q[g][1]);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      stp[a] = (si_prod_q[a] + 64'sd32768) >>> 16;
      sum[a] = 64'($signed(si_pos_q[a])) + stp[a];
      if (sum[a] > 64'sd2147483647) begin
        np[a] = 32'sh7fffffff;
      end else if (sum[a] < -64'sd2147483648) begin
        np[a] = 32'sh80000000;
      end else begin
        np[a] = sum[a][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      se_drop_q <= drop1;
      se_pos_q  <= dq.pos;
      for (int g = 0; g < 3; g++) begin
        for (int a = 0; a < 3; a++) begin
          se_w_q[g][a]  <= wsel[g][a];
          se_lp_q[g][a] <= lsel[g][a][0];
        end
      end
      sf_drop_q <= se_drop_q;
      sf_pos_q  <= se_pos_q;
      sf_w_q    <= se_w_q;
      sf_rx_q   <= rx;
      sg_drop_q <= sf_drop_q;
      sg_pos_q  <= sf_pos_q;
      sg_w_q    <= sf_w_q;
      sg_ry_q   <= ry;
      sh_drop_q <= sg_drop_q;
      sh_pos_q  <= sg_pos_q;
      for (int g = 0; g < 3; g++) begin
        sh_vel_q[g]  <= sgpa_pkg::blend(sg_ry_q[g][0], sg_ry_q[g][1], sg_w_q[g][2]);
        si_prod_q[g] <= $signed({1'b0, ts_q}) * sh_vel_q[g];
        sj_np_q[g]   <= np[g];
      end
      si_drop_q <= sh_drop_q;
      si_pos_q  <= sh_pos_q;
      sj_drop_q <= si_drop_q;
    end
  end

  // ---------------- second exit check and output register ----------------
  logic [95:0] out_data_q;
  logic        out_drop_q;

  always_comb begin
    drop2 = sj_drop_q;
    for (int a = 0; a < 3; a++) begin
      if (sj_np_q[a][31] || ({6'b0, sj_np_q[a][30:0]} >= lim[a])) begin
        drop2 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pipe_en) begin
      out_v_q <= sj_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_drop_q <= drop2;
      out_data_q <= drop2 ? '0 : {sj_np_q[2], sj_np_q[1], sj_np_q[0]};
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_drop_q;

  // ---------------- assertions ----------------
  `SGPA_ASSERT_IMP(a_drop_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "dropped request carries a position")
  `SGPA_ASSERT_IMP(a_kept_nonneg, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tdata[31] && !m_axis_tdata[63] && !m_axis_tdata[95], "kept particle has a negative coordinate")
  `SGPA_ASSERT_IMP(a_no_write_in_stall, !pipe_en, !ram_we_any, "grid written while the pipeline holds")

endmodule
`default_nettype wire
